// ===== src/time_bucket_row_partitioner_macros.svh =====
// ----------------------------------------------------------------------------
// time_bucket_row_partitioner_macros
// Assertion helpers for the time bucket row partitioner.
// ----------------------------------------------------------------------------
`ifndef TIME_BUCKET_ROW_PARTITIONER_MACROS_SVH
`define TIME_BUCKET_ROW_PARTITIONER_MACROS_SVH
// implication checked every cycle outside reset
`define TBRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication outside reset
`define TBRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/tbrp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbrp_pkg
// Types, constants and commands shared by the bucket partitioner modules.
// ----------------------------------------------------------------------------
`default_nettype none
package tbrp_pkg;
  localparam int MAX_BUCKETS = 16;
  localparam int KEY_BITS = 64;
  localparam int IDX_W = $clog2(MAX_BUCKETS);
  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
  localparam int DIV_CNT_W = 7;

  localparam logic [1:0] REG_BUCKET_WIDTH = 2'd0;
  localparam logic [1:0] REG_TRACK_MIN_MAX = 2'd1;
  localparam logic [1:0] REG_SIGNED_VALUES = 2'd2;

  typedef struct packed {
    logic [63:0] row_value;
    logic        last_row;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] bucket_start;
    logic [3:0]  bucket_index;
    logic        new_bucket;
    logic        table_full;
    logic [63:0] min_key;
    logic [63:0] max_key;
    logic        end_of_block;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ROUND, ST_SEARCH, ST_ROW, ST_SUM
  } state_t;

  typedef struct packed {
    logic load;       // capture input word, start division
    logic div_step;   // one quotient bit
    logic round_dn;   // key minus remainder -> start
    logic search;     // examine table entry at scan index
    logic row_out;    // load row result, update table
    logic sum_out;    // load summary of entry at scan index
    logic scan_clr;
    logic scan_inc;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic hit;
    logic scan_end;   // scan index reached bucket_count; during sum_out, last summary entry reached
    logic last;
    logic empty_next; // no summaries after the row word
  } stat_t;
endpackage
`default_nettype wire

// ===== src/time_bucket_row_partitioner.sv =====
// ----------------------------------------------------------------------------
// time_bucket_row_partitioner
// Rounds row keys down to bucket starts and numbers buckets per block.
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       input      in_valid/in_ready     row_value, last_row
// out      output     out_valid/out_ready   one result word
// cfg      input      cfg_valid/cfg_ready   cfg_index, cfg_data
// Each row is accepted in the idle state, then passes through the divide,
// round-down, table-scan and row-word states; a new row is taken only
// once the sequencer is back in idle.
// A last row is followed by one summary word per stored bucket.
// Output stalls hold the sequencer in its output states.
// Reset clears the bucket count and configuration to width 1, both flags off.
`default_nettype none
module time_bucket_row_partitioner (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tbrp_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tbrp_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);
  tbrp_pkg::cmd_t  cmd;
  tbrp_pkg::stat_t st;
  logic out_busy, idle;

  assign in_ready = idle;
  assign cfg_ready = 1'b1;

  tbrp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready), .out_busy(out_busy),
    .st(st), .cmd(cmd), .idle(idle)
  );

  tbrp_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(in_data),
    .cfg_fire(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_ready(out_ready), .st(st), .out_busy(out_busy),
    .out_valid(out_valid), .out_word(out_data)
  );
endmodule
`default_nettype wire

// ===== src/tbrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbrp_ctrl
// Sequencer: divide, round down, table scan, row word, summary words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "time_bucket_row_partitioner_macros.svh"
module tbrp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire logic            out_busy,
  input  wire tbrp_pkg::stat_t st,
  output tbrp_pkg::cmd_t       cmd,
  output logic                 idle
);
  tbrp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= tbrp_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    unique case (state)
      tbrp_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = tbrp_pkg::ST_DIV;
        end
      end
      tbrp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_next = tbrp_pkg::ST_ROUND;
      end
      tbrp_pkg::ST_ROUND: begin
        cmd.round_dn = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next = tbrp_pkg::ST_SEARCH;
      end
      tbrp_pkg::ST_SEARCH: begin
        if (st.hit || st.scan_end) begin
          state_next = tbrp_pkg::ST_ROW;
        end else begin
          cmd.search = 1'b1;
          cmd.scan_inc = 1'b1;
        end
      end
      tbrp_pkg::ST_ROW: begin
        if (!out_busy) begin
          cmd.row_out = 1'b1;
          cmd.scan_clr = 1'b1;
          if (st.last && !st.empty_next) state_next = tbrp_pkg::ST_SUM;
          else state_next = tbrp_pkg::ST_IDLE;
        end
      end
      tbrp_pkg::ST_SUM: begin
        if (!out_busy) begin
          cmd.sum_out = 1'b1;
          cmd.scan_inc = 1'b1;
          if (st.scan_end) state_next = tbrp_pkg::ST_IDLE;
        end
      end
      default: state_next = tbrp_pkg::ST_IDLE;
    endcase
  end

  `TBRP_ASSERT_IMP(a_load_idle, cmd.load, state == tbrp_pkg::ST_IDLE, "load outside idle")
  `TBRP_ASSERT_NEXT(a_div_after_load, cmd.load, state == tbrp_pkg::ST_DIV, "no divide after load")
  `TBRP_ASSERT_IMP(a_one_out, 1'b1, !(cmd.row_out && cmd.sum_out), "two words at once")
endmodule
`default_nettype wire

// ===== src/tbrp_dpath.sv =====
// ----------------------------------------------------------------------------
// tbrp_dpath
// Restoring divider, start rounding, bucket table and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module tbrp_dpath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tbrp_pkg::cmd_t    cmd,
  input  wire tbrp_pkg::in_word_t in_word,
  input  wire logic              cfg_fire,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  input  wire logic              out_ready,
  output tbrp_pkg::stat_t        st,
  output logic                   out_busy,
  output logic                   out_valid,
  output tbrp_pkg::out_word_t    out_word
);
  localparam logic [63:0] KMASK = {64{1'b1}} >> (64 - tbrp_pkg::KEY_BITS);
  localparam logic [63:0] KSIGN = 64'd1 << (tbrp_pkg::KEY_BITS - 1);

  logic [63:0] width_r;
  logic        track;
  logic        sgn;
  logic [63:0] key, w, quo, rem, start;
  logic        last;
  logic [tbrp_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [tbrp_pkg::CNT_W-1:0] count, scan;
  logic [tbrp_pkg::IDX_W-1:0] hit_idx;
  logic        hit;
  logic [63:0] keys [tbrp_pkg::MAX_BUCKETS];
  logic [63:0] mins [tbrp_pkg::MAX_BUCKETS];
  logic [63:0] maxs [tbrp_pkg::MAX_BUCKETS];

  logic [63:0] kin;
  logic [64:0] rem_sh, rem_sub;
  logic [tbrp_pkg::IDX_W-1:0] sidx;
  logic [63:0] mn_e, mx_e;
  logic        lt_min, gt_max;
  logic        new_ok;
  logic [tbrp_pkg::CNT_W-1:0] sum_cnt;

  assign sidx = scan[tbrp_pkg::IDX_W-1:0];

  always_comb begin
    kin = in_word.row_value & KMASK;
    if (sgn && (kin & KSIGN) != 64'd0) kin = kin | ~KMASK;
  end

  assign rem_sh = {rem, quo[63]};
  assign rem_sub = rem_sh - {1'b0, w};

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r <= 64'd1;
      track <= 1'b0;
      sgn <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        tbrp_pkg::REG_BUCKET_WIDTH:  width_r <= cfg_data;
        tbrp_pkg::REG_TRACK_MIN_MAX: track <= cfg_data[0];
        tbrp_pkg::REG_SIGNED_VALUES: sgn <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // divider: quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= kin;
      quo <= kin;
      rem <= 64'd0;
      last <= in_word.last_row;
      w <= (width_r == 64'd0) ? 64'd1 : width_r;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (!rem_sub[64]) begin
        rem <= rem_sub[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
    // key = quotient * width + remainder
    if (cmd.round_dn) start <= key - rem;
  end
  assign st.div_done = (div_cnt == 7'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
      hit <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        scan <= '0;
        hit <= 1'b0;
      end else if (cmd.search && keys[sidx] == start) begin
        hit <= 1'b1;
        hit_idx <= sidx;
      end else if (cmd.scan_inc) scan <= scan + 1'b1;
    end
  end

  assign st.hit = hit;
  assign st.scan_end = cmd.sum_out ? (scan + 1'b1 == sum_cnt) : (scan == count);
  assign st.last = last;
  assign mn_e = mins[hit_idx];
  assign mx_e = maxs[hit_idx];
  assign lt_min = sgn ? ($signed(key) < $signed(mn_e)) : (key < mn_e);
  assign gt_max = sgn ? ($signed(mx_e) < $signed(key)) : (mx_e < key);
  assign new_ok = !hit && (count < tbrp_pkg::MAX_BUCKETS[tbrp_pkg::CNT_W-1:0]);
  assign st.empty_next = (count == '0) && !new_ok;

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.row_out) begin
      if (last) count <= '0;
      else if (new_ok) count <= count + 1'b1;
    end else if (cmd.sum_out && st.scan_end) count <= '0;
    if (cmd.row_out) begin
      if (hit) begin
        if (lt_min) mins[hit_idx] <= key;
        if (gt_max) maxs[hit_idx] <= key;
      end else if (new_ok) begin
        keys[count[tbrp_pkg::IDX_W-1:0]] <= start;
        mins[count[tbrp_pkg::IDX_W-1:0]] <= key;
        maxs[count[tbrp_pkg::IDX_W-1:0]] <= key;
      end
    end
  end

  // count is cleared on row_out of a last row; summaries need the old count
  always_ff @(posedge clk) begin
    if (cmd.row_out) sum_cnt <= count + {{(tbrp_pkg::CNT_W-1){1'b0}}, new_ok};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.row_out || cmd.sum_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.row_out) begin
      out_word.result_kind <= 1'b0;
      out_word.bucket_start <= start;
      out_word.bucket_index <= hit ? 4'(hit_idx) : (new_ok ? 4'(count) : 4'd0);
      out_word.new_bucket <= !hit;
      out_word.table_full <= !hit && !new_ok;
      out_word.min_key <= 64'd0;
      out_word.max_key <= 64'd0;
      out_word.end_of_block <= last && st.empty_next;
    end else if (cmd.sum_out) begin
      out_word.result_kind <= 1'b1;
      out_word.bucket_start <= keys[sidx];
      out_word.bucket_index <= 4'(sidx);
      out_word.new_bucket <= 1'b0;
      out_word.table_full <= 1'b0;
      out_word.min_key <= track ? mins[sidx] : 64'd0;
      out_word.max_key <= track ? maxs[sidx] : 64'd0;
      out_word.end_of_block <= (scan + 1'b1 == sum_cnt);
    end
  end
  assign out_busy = out_valid && !out_ready;
endmodule
`default_nettype wire
